[design/sfprc_pkg.sv]
package sfprc_pkg;

    localparam int CH_W     = 11;
    localparam int TICK_W   = 16;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int X_W      = 17;
    localparam int SPAN_W   = 12;
    localparam int PROD_W   = X_W + SPAN_W;
    localparam int DIV_W    = 24;
    localparam int RECIP_W  = 25;
    localparam int MUL_W    = DIV_W + RECIP_W;
    localparam int QUOT_W   = 20;
    localparam int SUM_W    = 22;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int KEEP_BYTES = 12;

    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2_BYTE = 8'hBB;

    // stick input range is -100..100, so the roll/pitch offset is 100
    localparam logic signed [X_W-1:0] STICK_OFFSET = 17'sd100;

    // floor(n / 25) = (n * RECIP_25) >> RECIP_SHIFT, exact for n < 2**24
    localparam logic [RECIP_W-1:0] RECIP_25    = 25'd21474837;
    localparam int                 RECIP_SHIFT = 29;

    localparam logic [CH_W-1:0]   CH_MIN_RST     = 11'd172;
    localparam logic [CH_W-1:0]   CH_MID_RST     = 11'd992;
    localparam logic [CH_W-1:0]   CH_MAX_RST     = 11'd1811;
    localparam logic [TICK_W-1:0] FAILSAFE_RST   = 16'd500;
    localparam logic [TICK_W-1:0] FRAME_PER_RST  = 16'd20;
    localparam logic [CH_W-1:0]   CH_SAT_MAX     = 11'd2047;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef enum logic [2:0] {
        REG_CH_MIN,
        REG_CH_MID,
        REG_CH_MAX,
        REG_FAILSAFE,
        REG_FRAME_PERIOD
    } reg_index_t;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] roll_channel;
        logic [CH_W-1:0] pitch_channel;
        logic [CH_W-1:0] throttle_channel;
        logic [CH_W-1:0] yaw_channel;
        logic            packet_accepted;
        logic            failsafe_active;
        logic            frame_due;
    } result_t;

    // per-item flags that travel alongside the mapping pipeline
    typedef struct packed {
        logic valid;
        logic accepted;
        logic safe;
        logic due;
    } flags_t;

endpackage

[design/sfprc_map.sv]
module sfprc_map
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [sfprc_pkg::X_W-1:0]       x,
    input  logic                                   coarse,
    input  logic signed [sfprc_pkg::SPAN_W-1:0]    span,
    input  logic        [sfprc_pkg::CH_W-1:0]      base,
    output logic        [sfprc_pkg::CH_W-1:0]      value
);
    import sfprc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     coarse_reg;
    logic [MUL_W-1:0]         recip_reg;
    logic [MUL_W-1:0]         recip_next;
    logic                     neg_reg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        shifted;
    logic [QUOT_W-1:0]        quot;
    logic signed [SUM_W-1:0]  quot_s;
    logic signed [SUM_W-1:0]  total;

    assign prod_next = PROD_W'(x) * PROD_W'(span);

    // truncating division: divide the magnitude, then put the sign back
    // /200 is >>3 then /25, /100 is >>2 then /25
    always_comb
    begin
        mag        = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        shifted    = coarse_reg ? (mag >> 3) : (mag >> 2);
        recip_next = MUL_W'(shifted[DIV_W-1:0]) * MUL_W'(RECIP_25);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            coarse_reg <= coarse;
            recip_reg  <= recip_next;
            neg_reg    <= prod_reg[PROD_W-1];
        end
    end

    always_comb
    begin
        quot   = recip_reg[RECIP_SHIFT +: QUOT_W];
        quot_s = neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        total  = quot_s + $signed(SUM_W'(base));
        if (total < 0)
        begin
            value = '0;
        end
        else if (total > $signed(SUM_W'(CH_SAT_MAX)))
        begin
            value = CH_SAT_MAX;
        end
        else
        begin
            value = total[CH_W-1:0];
        end
    end

endmodule

[design/sync_framed_packet_to_rc_channels_core.sv]
// Channel   Handshake                    Payload
// item      item_valid / item_ready      item   (action, data_byte)
// result    result_valid / result_ready  result (channels and status flags)
// config    APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One item per cycle unless a held result stalls the pipeline.
// The pipeline is input register, parser/tick stage, two multiply stages and
// the result register; the multipliers in the mapping set the depth.
// Reset clears parser, counters, channel values and config to defaults.
// A held result stalls every stage at once; item_ready is high unless a result is held without result_ready.
module sync_framed_packet_to_rc_channels_core
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  sfprc_pkg::item_t                 item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output sfprc_pkg::result_t               result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfprc_pkg::ADDR_W-1:0]     paddr,
    input  logic [sfprc_pkg::DATA_W-1:0]     pwdata,
    output logic [sfprc_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);
    import sfprc_pkg::*;

    // configuration
    logic [CH_W-1:0]   ch_min_reg;
    logic [CH_W-1:0]   ch_mid_reg;
    logic [CH_W-1:0]   ch_max_reg;
    logic [TICK_W-1:0] failsafe_reg;
    logic [TICK_W-1:0] frame_period_reg;
    reg_index_t        reg_index;
    logic              cfg_write;

    // pipeline control
    logic   en;
    logic   a_valid_reg;
    item_t  a_item_reg;
    flags_t b_flags_reg;
    flags_t b_flags_next;
    flags_t c_flags_reg;
    flags_t d_flags_reg;

    // parser
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEN_W-1:0]   exp_len_reg;
    logic [LEN_W-1:0]   exp_len_next;
    logic [LEN_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   pos_next;
    logic [LEN_W-1:0]   pos_inc;
    logic [BYTE_W-1:0]  check_reg;
    logic [BYTE_W-1:0]  check_next;
    logic [BYTE_W-1:0]  store_reg [KEEP_BYTES];
    logic               store_we;
    logic               byte_ev;
    logic               tick_ev;
    logic               len_ok;
    logic               good_frame;
    logic [BYTE_W-1:0]  rx;

    // tick counters
    logic [TICK_W-1:0] tsp_reg;
    logic [TICK_W-1:0] tsp_next;
    logic [TICK_W-1:0] tsf_reg;
    logic [TICK_W-1:0] tsf_next;
    logic [TICK_W-1:0] tsf_inc;
    logic              due;

    // stick values
    logic signed [WORD_W-1:0] pitch_diff;
    logic signed [WORD_W-1:0] roll_diff;
    logic signed [X_W-1:0]    xp_reg;
    logic signed [X_W-1:0]    xr_reg;
    logic signed [X_W-1:0]    xt_reg;
    logic signed [SPAN_W-1:0] span;
    logic [CH_W-1:0]          pitch_map;
    logic [CH_W-1:0]          roll_map;
    logic [CH_W-1:0]          thr_map;

    logic [CH_W-1:0] roll_reg;
    logic [CH_W-1:0] roll_next;
    logic [CH_W-1:0] pitch_reg;
    logic [CH_W-1:0] pitch_next;
    logic [CH_W-1:0] thr_reg;
    logic [CH_W-1:0] thr_next;
    logic            result_valid_reg;
    result_t         result_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_min_reg       <= CH_MIN_RST;
            ch_mid_reg       <= CH_MID_RST;
            ch_max_reg       <= CH_MAX_RST;
            failsafe_reg     <= FAILSAFE_RST;
            frame_period_reg <= FRAME_PER_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_CH_MIN:       ch_min_reg       <= pwdata[CH_W-1:0];
                REG_CH_MID:       ch_mid_reg       <= pwdata[CH_W-1:0];
                REG_CH_MAX:       ch_max_reg       <= pwdata[CH_W-1:0];
                REG_FAILSAFE:     failsafe_reg     <= pwdata[TICK_W-1:0];
                REG_FRAME_PERIOD: frame_period_reg <= pwdata[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CH_MIN:       prdata = DATA_W'(ch_min_reg);
            REG_CH_MID:       prdata = DATA_W'(ch_mid_reg);
            REG_CH_MAX:       prdata = DATA_W'(ch_max_reg);
            REG_FAILSAFE:     prdata = DATA_W'(failsafe_reg);
            REG_FRAME_PERIOD: prdata = DATA_W'(frame_period_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign en         = !result_valid_reg || result_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= item;
        end
    end

    // ---------------- parser ----------------
    assign rx      = a_item_reg.data_byte;
    assign byte_ev = en && a_valid_reg && !a_item_reg.action;
    assign tick_ev = en && a_valid_reg && a_item_reg.action;
    assign len_ok  = (rx != '0) && (rx <= BYTE_W'(MAX_PAYLOAD));
    assign pos_inc = pos_reg + LEN_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_ev)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx == SYNC1_BYTE)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2: phase_next = (rx == SYNC2_BYTE) ? PH_LEN : PH_SYNC1;
                PH_LEN:   phase_next = len_ok ? PH_DATA : PH_SYNC1;
                PH_DATA:  phase_next = (pos_inc >= exp_len_reg) ? PH_CHECK : PH_DATA;
                PH_CHECK: phase_next = PH_SYNC1;
                default:  phase_next = PH_SYNC1;
            endcase
        end
    end

    always_comb
    begin
        exp_len_next = exp_len_reg;
        pos_next     = pos_reg;
        check_next   = check_reg;
        store_we     = 1'b0;
        good_frame   = 1'b0;
        if (byte_ev)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        exp_len_next = rx[LEN_W-1:0];
                        pos_next     = '0;
                        check_next   = rx;
                    end
                end
                PH_DATA:
                begin
                    store_we   = (pos_reg < LEN_W'(KEEP_BYTES));
                    check_next = check_reg ^ rx;
                    pos_next   = pos_inc;
                end
                PH_CHECK:
                begin
                    good_frame = (rx == check_reg) && (exp_len_reg >= LEN_W'(KEEP_BYTES));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            exp_len_reg <= '0;
            pos_reg     <= '0;
            check_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            pos_reg     <= pos_next;
            check_reg   <= check_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[pos_reg[3:0]] <= rx;
        end
    end

    // ---------------- tick counters ----------------
    always_comb
    begin
        tsp_next = tsp_reg;
        tsf_next = tsf_reg;
        tsf_inc  = (tsf_reg == '1) ? tsf_reg : tsf_reg + TICK_W'(1);
        due      = 1'b0;
        if (good_frame)
        begin
            tsp_next = '0;
        end
        else if (tick_ev && (tsp_reg != '1))
        begin
            tsp_next = tsp_reg + TICK_W'(1);
        end
        if (tick_ev)
        begin
            if (tsf_inc >= frame_period_reg)
            begin
                due      = 1'b1;
                tsf_next = '0;
            end
            else
            begin
                tsf_next = tsf_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsp_reg <= '0;
            tsf_reg <= '0;
        end
        else
        begin
            tsp_reg <= tsp_next;
            tsf_reg <= tsf_next;
        end
    end

    // ---------------- stage B: flags and stick values ----------------
    assign pitch_diff = $signed({store_reg[0], store_reg[1]} - {store_reg[2], store_reg[3]});
    assign roll_diff  = $signed({store_reg[6], store_reg[7]} - {store_reg[4], store_reg[5]});

    always_comb
    begin
        b_flags_next.valid    = a_valid_reg;
        b_flags_next.accepted = good_frame;
        b_flags_next.safe     = tsp_next > failsafe_reg;
        b_flags_next.due      = due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_flags_reg <= '0;
            c_flags_reg <= '0;
            d_flags_reg <= '0;
        end
        else if (en)
        begin
            b_flags_reg <= b_flags_next;
            c_flags_reg <= b_flags_reg;
            d_flags_reg <= c_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg <= X_W'(pitch_diff) + STICK_OFFSET;
            xr_reg <= X_W'(roll_diff) + STICK_OFFSET;
            xt_reg <= X_W'($signed({store_reg[8], store_reg[9]}));
        end
    end

    // ---------------- mapping ----------------
    assign span = $signed(SPAN_W'(ch_max_reg)) - $signed(SPAN_W'(ch_min_reg));

    sfprc_map u_map_pitch
    (
        .clk    (clk),
        .en     (en),
        .x      (xp_reg),
        .coarse (1'b1),
        .span   (span),
        .base   (ch_min_reg),
        .value  (pitch_map)
    );

    sfprc_map u_map_roll
    (
        .clk    (clk),
        .en     (en),
        .x      (xr_reg),
        .coarse (1'b1),
        .span   (span),
        .base   (ch_min_reg),
        .value  (roll_map)
    );

    sfprc_map u_map_thr
    (
        .clk    (clk),
        .en     (en),
        .x      (xt_reg),
        .coarse (1'b0),
        .span   (span),
        .base   (ch_min_reg),
        .value  (thr_map)
    );

    // ---------------- channel values and result register ----------------
    always_comb
    begin
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        thr_next   = thr_reg;
        if (d_flags_reg.valid)
        begin
            if (d_flags_reg.accepted)
            begin
                roll_next  = roll_map;
                pitch_next = pitch_map;
                thr_next   = thr_map;
            end
            if (d_flags_reg.safe)
            begin
                roll_next  = ch_mid_reg;
                pitch_next = ch_mid_reg;
                thr_next   = ch_min_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg         <= CH_MID_RST;
            pitch_reg        <= CH_MID_RST;
            thr_reg          <= CH_MIN_RST;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            roll_reg         <= roll_next;
            pitch_reg        <= pitch_next;
            thr_reg          <= thr_next;
            result_valid_reg <= d_flags_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.roll_channel     <= roll_next;
            result_reg.pitch_channel    <= pitch_next;
            result_reg.throttle_channel <= thr_next;
            result_reg.yaw_channel      <= ch_mid_reg;
            result_reg.packet_accepted  <= d_flags_reg.accepted;
            result_reg.failsafe_active  <= d_flags_reg.safe;
            result_reg.frame_due        <= d_flags_reg.due;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
